FILE: hw/rtl/fmmap_pkg.sv
// fmmap_pkg: types, codes, constant tables and helper functions shared by
// the MIDI-to-FM channel mapper modules.
// No dependencies.
`default_nettype none

package fmmap_pkg;

	// channel count and derived index width
	localparam int NUM_CHANNELS = 6;
	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [3:0] CHAN_COUNT = 4'(NUM_CHANNELS);

	// percussion key table depth (one entry per MIDI note)
	localparam int KEY_DEPTH = 128;

	// command slots per event
	localparam int MAX_CMDS = 4;
	localparam int IDX_W = 2;
	localparam int CNT_W = 3;

	// note window and pitch arithmetic
	localparam logic [6:0] LOW_NOTE = 7'd11;
	localparam logic [6:0] HIGH_NOTE = 7'd106;
	localparam logic [7:0] STEPS = 8'd12;
	localparam logic [15:0] STEP_RECIP = 16'd171;   // 2^11 / 12, rounded up
	localparam logic [13:0] BEND_CENTER = 14'h2000;
	localparam logic [23:0] BEND_RECIP = 24'd1310;  // 2^16 / 50, rounded down
	localparam logic [13:0] BEND_DIV = 14'd50;
	localparam logic [13:0] LEVEL_MAX = 14'h7F;
	localparam logic [6:0] PAN_RIGHT_MIN = 7'd96;
	localparam logic [6:0] PAN_CENTER_MIN = 7'd31;

	localparam logic [10:0] FNUM_TABLE [12] = '{
		11'd617, 11'd653, 11'd692, 11'd733, 11'd777, 11'd823,
		11'd872, 11'd924, 11'd979, 11'd1037, 11'd1099, 11'd1164
	};

	typedef enum logic [2:0] {
		OP_NOTE_ON       = 3'd0,
		OP_NOTE_OFF      = 3'd1,
		OP_VOLUME        = 3'd2,
		OP_BEND          = 3'd3,
		OP_PROGRAM       = 3'd4,
		OP_PERCUSSIVE    = 3'd5,
		OP_PAN           = 3'd6,
		OP_LOAD_PERC_KEY = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		CMD_VOLUME           = 3'd0,
		CMD_PITCH            = 3'd1,
		CMD_KEY_ON           = 3'd2,
		CMD_KEY_OFF          = 3'd3,
		CMD_STEREO           = 3'd4,
		CMD_LOAD_PRESET      = 3'd5,
		CMD_LOAD_PERC_PRESET = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_LEFT   = 2'd0,
		ST_CENTER = 2'd1,
		ST_RIGHT  = 2'd2
	} stereo_t;

	// one MIDI event item
	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  chan;
		logic [6:0]  note;
		logic [6:0]  velocity;
		logic [6:0]  volume;
		logic [13:0] bend;
		logic [6:0]  program_req;
		logic        enabled;
		logic [6:0]  pan;
		logic [6:0]  perc_key;
	} midi_item_t;

	// one FM command item
	typedef struct packed {
		logic [2:0]  cmd;
		logic [2:0]  out_chan;
		logic [6:0]  level;
		logic [3:0]  octave;
		logic [10:0] fnum;
		logic [1:0]  stereo;
		logic [6:0]  preset_index;
		logic        is_last;
	} fm_item_t;

	// per-channel state word
	typedef struct packed {
		logic [6:0] pitch;
		logic [6:0] volume;
		logic [6:0] velocity;
		logic [6:0] pan;
		logic       perc;
	} chan_entry_t;

	localparam chan_entry_t CHAN_RESET = '{
		pitch: 7'd0, volume: 7'h7F, velocity: 7'h7F, pan: 7'd0, perc: 1'b0
	};

	// stage 1 to stage 2 hand-over
	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  chan;
		logic        ok;
		logic        perc;
		logic [6:0]  note;
		logic [6:0]  pitch;
		logic [6:0]  program_req;
		logic [6:0]  pan;
		logic [13:0] level_prod;
		logic        bend_neg;
		logic [13:0] bend_mag;
		logic [23:0] bend_prod;
	} s1_t;

	// commands produced by one event
	typedef struct packed {
		fm_item_t [MAX_CMDS-1:0] slots;
		logic [CNT_W-1:0]        count;
	} bundle_t;

	typedef struct packed {
		logic [3:0]  octave;
		logic [10:0] base;
	} key_info_t;

	// octave and base F-number of a key; (key-11) is taken on 8 bits
	function automatic key_info_t key_split(input logic [6:0] key);
		logic [7:0]  d;
		logic [15:0] p;
		logic [4:0]  q;
		logic [7:0]  r;
		key_info_t   ki;
		d = {1'b0, key} - {1'b0, LOW_NOTE};
		p = {8'd0, d} * STEP_RECIP;
		q = p[15:11];
		r = d - ({3'd0, q} * STEPS);
		ki.base = FNUM_TABLE[r[3:0]];
		ki.octave = (key < LOW_NOTE) ? 4'd0 : q[3:0];
		return ki;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fmmap_state.sv
// fmmap_state: stage 1 of the mapper. Holds the channel state memory and the
// percussion key memory, and does the read-modify-write of channel state.
// Depends on fmmap_pkg.
`default_nettype none

module fmmap_state (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               midi_valid,
	output logic                    midi_ready,
	input  wire fmmap_pkg::midi_item_t midi,
	input  wire logic               s2_ready,
	output logic                    s1_valid,
	output fmmap_pkg::s1_t          s1
);

	// memories
	fmmap_pkg::chan_entry_t chan_mem_q [fmmap_pkg::NUM_CHANNELS];
	logic [fmmap_pkg::NUM_CHANNELS-1:0] chan_vld_q;
	logic [6:0] key_mem_q [fmmap_pkg::KEY_DEPTH];

	// stage 1 registers
	logic                   s1_valid_q;
	fmmap_pkg::midi_item_t  item_s1;
	fmmap_pkg::chan_entry_t ent_rd_q;
	logic [6:0]             key_rd_q;

	logic accept;
	logic s1_go;
	logic chan_ok;
	logic note_ok;
	logic rd_ok;
	logic [fmmap_pkg::CH_IDX_W-1:0] rd_idx;
	logic [fmmap_pkg::CH_IDX_W-1:0] wr_idx;
	logic [6:0] key;
	fmmap_pkg::chan_entry_t wr_ent;
	logic wr_en;
	logic key_wr;
	logic [13:0] bend_mag;
	logic bend_neg;

	// handshake
	assign s1_go = s1_valid_q & s2_ready;
	assign midi_ready = ~s1_valid_q | s2_ready;
	assign accept = midi_valid & midi_ready;
	assign s1_valid = s1_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (midi_ready) begin
			s1_valid_q <= midi_valid;
		end
	end

	// decode of the item in stage 1
	assign chan_ok = ({1'b0, item_s1.chan} < fmmap_pkg::CHAN_COUNT);
	assign note_ok = (item_s1.note >= fmmap_pkg::LOW_NOTE) &&
		(item_s1.note <= fmmap_pkg::HIGH_NOTE);
	assign key = ent_rd_q.perc ? key_rd_q : item_s1.note;
	assign wr_idx = item_s1.chan[fmmap_pkg::CH_IDX_W-1:0];
	assign rd_idx = midi.chan[fmmap_pkg::CH_IDX_W-1:0];
	assign rd_ok = ({1'b0, midi.chan} < fmmap_pkg::CHAN_COUNT);

	// modify the channel word
	always_comb begin
		wr_ent = ent_rd_q;
		case (item_s1.op)
			fmmap_pkg::OP_NOTE_ON: begin
				if (note_ok) begin
					wr_ent.velocity = item_s1.velocity;
					wr_ent.pitch = key;
				end
			end
			fmmap_pkg::OP_VOLUME: wr_ent.volume = item_s1.volume;
			fmmap_pkg::OP_PERCUSSIVE: wr_ent.perc = item_s1.enabled;
			fmmap_pkg::OP_PAN: wr_ent.pan = item_s1.pan;
			default: wr_ent = ent_rd_q;
		endcase
	end

	assign wr_en = s1_go & chan_ok & (item_s1.op != fmmap_pkg::OP_LOAD_PERC_KEY);
	assign key_wr = s1_go & (item_s1.op == fmmap_pkg::OP_LOAD_PERC_KEY);

	// read port: registered, with forwarding of the write in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= midi;
			if (key_wr && (item_s1.note == midi.note)) begin
				key_rd_q <= item_s1.perc_key;
			end else begin
				key_rd_q <= key_mem_q[midi.note];
			end
			if (wr_en && (wr_idx == rd_idx)) begin
				ent_rd_q <= wr_ent;
			end else if (rd_ok && chan_vld_q[rd_idx]) begin
				ent_rd_q <= chan_mem_q[rd_idx];
			end else begin
				ent_rd_q <= fmmap_pkg::CHAN_RESET;
			end
		end
	end

	// write ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			chan_mem_q[wr_idx] <= wr_ent;
		end
		if (key_wr) begin
			key_mem_q[item_s1.note] <= item_s1.perc_key;
		end
	end

	// channel word valid bits; an unwritten channel reads as its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_vld_q <= '0;
		end else if (wr_en) begin
			chan_vld_q[wr_idx] <= 1'b1;
		end
	end

	// bend magnitude around center
	assign bend_neg = (item_s1.bend < fmmap_pkg::BEND_CENTER);
	assign bend_mag = bend_neg ? (fmmap_pkg::BEND_CENTER - item_s1.bend) :
		(item_s1.bend - fmmap_pkg::BEND_CENTER);

	// hand-over to stage 2
	always_comb begin
		s1.op = item_s1.op;
		s1.chan = item_s1.chan;
		s1.ok = chan_ok & ((item_s1.op != fmmap_pkg::OP_NOTE_ON) | note_ok);
		s1.perc = ent_rd_q.perc;
		s1.note = item_s1.note;
		s1.pitch = wr_ent.pitch;
		s1.program_req = item_s1.program_req;
		s1.pan = wr_ent.pan;
		s1.level_prod = {7'd0, wr_ent.volume} * {7'd0, wr_ent.velocity};
		s1.bend_neg = bend_neg;
		s1.bend_mag = bend_mag;
		s1.bend_prod = {10'd0, bend_mag} * fmmap_pkg::BEND_RECIP;
	end

	// a stalled stage 1 item and its read data hold
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s2_ready) |=> ($stable(item_s1) && $stable(ent_rd_q)))
		else $error("stage 1 item changed while stalled");

	// no write to channel state without a live stage 1 item
	a_wr_live: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en || key_wr) |-> s1_valid_q)
		else $error("state write without a stage 1 item");

endmodule

`default_nettype wire

FILE: hw/rtl/fmmap_calc.sv
// fmmap_calc: stage 2 of the mapper. Finishes level, octave, F-number and
// stereo, and builds the list of commands of one event.
// Depends on fmmap_pkg.
`default_nettype none

module fmmap_calc (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s1_valid,
	input  wire fmmap_pkg::s1_t   s1,
	output logic                  s2_ready,
	input  wire logic             free,
	output logic                  bundle_valid,
	output fmmap_pkg::bundle_t    bundle
);

	logic           s2_valid_q;
	fmmap_pkg::s1_t s2_q;
	logic           s2_go;

	// level = volume * velocity / 127
	logic [20:0] lvl_t;
	logic [6:0]  lvl_q0;
	logic [13:0] lvl_qm;
	logic [13:0] lvl_r;
	logic [6:0]  level;

	// bend quotient and F-number
	logic [7:0]  bq0;
	logic [13:0] b50;
	logic [13:0] br;
	logic [7:0]  bq;
	logic [11:0] fsum;
	fmmap_pkg::key_info_t ki;
	logic [1:0]  stereo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_ready) begin
			s2_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s1_valid) begin
			s2_q <= s1;
		end
	end

	// reciprocal multiply by 129/2^14, one correction step
	always_comb begin
		lvl_t = {s2_q.level_prod, 7'd0} + {7'd0, s2_q.level_prod};
		lvl_q0 = lvl_t[20:14];
		lvl_qm = {lvl_q0, 7'd0} - {7'd0, lvl_q0};
		lvl_r = s2_q.level_prod - lvl_qm;
		level = (lvl_r >= fmmap_pkg::LEVEL_MAX) ? (lvl_q0 + 7'd1) : lvl_q0;
	end

	// bend magnitude / 50, one correction step, then signed add to base
	always_comb begin
		ki = fmmap_pkg::key_split(s2_q.pitch);
		bq0 = s2_q.bend_prod[23:16];
		b50 = ({6'd0, bq0} << 5) + ({6'd0, bq0} << 4) + ({6'd0, bq0} << 1);
		br = s2_q.bend_mag - b50;
		bq = (br >= fmmap_pkg::BEND_DIV) ? (bq0 + 8'd1) : bq0;
		fsum = s2_q.bend_neg ? ({1'b0, ki.base} - {4'd0, bq}) :
			({1'b0, ki.base} + {4'd0, bq});
	end

	// pan to stereo
	always_comb begin
		if (s2_q.pan > fmmap_pkg::PAN_RIGHT_MIN) begin
			stereo = fmmap_pkg::ST_RIGHT;
		end else if (s2_q.pan > fmmap_pkg::PAN_CENTER_MIN) begin
			stereo = fmmap_pkg::ST_CENTER;
		end else begin
			stereo = fmmap_pkg::ST_LEFT;
		end
	end

	// command list
	always_comb begin
		fmmap_pkg::fm_item_t nil;
		fmmap_pkg::fm_item_t c_vol;
		fmmap_pkg::fm_item_t c_pitch;
		fmmap_pkg::fm_item_t c_keyon;
		fmmap_pkg::fm_item_t c_keyoff;
		fmmap_pkg::fm_item_t c_bend;
		fmmap_pkg::fm_item_t c_stereo;
		fmmap_pkg::fm_item_t c_preset;
		fmmap_pkg::fm_item_t c_perc;
		nil = '0;
		nil.out_chan = s2_q.chan;
		c_vol = nil;
		c_vol.cmd = fmmap_pkg::CMD_VOLUME;
		c_vol.level = level;
		c_pitch = nil;
		c_pitch.cmd = fmmap_pkg::CMD_PITCH;
		c_pitch.octave = ki.octave;
		c_pitch.fnum = ki.base;
		c_bend = c_pitch;
		c_bend.fnum = fsum[10:0];
		c_keyon = nil;
		c_keyon.cmd = fmmap_pkg::CMD_KEY_ON;
		c_keyoff = nil;
		c_keyoff.cmd = fmmap_pkg::CMD_KEY_OFF;
		c_stereo = nil;
		c_stereo.cmd = fmmap_pkg::CMD_STEREO;
		c_stereo.stereo = stereo;
		c_preset = nil;
		c_preset.cmd = fmmap_pkg::CMD_LOAD_PRESET;
		c_preset.preset_index = s2_q.program_req;
		c_perc = nil;
		c_perc.cmd = fmmap_pkg::CMD_LOAD_PERC_PRESET;
		c_perc.preset_index = s2_q.note;

		bundle.slots = '0;
		bundle.count = '0;
		if (s2_q.ok) begin
			case (s2_q.op)
				fmmap_pkg::OP_NOTE_ON: begin
					if (s2_q.perc) begin
						bundle.slots[0] = c_perc;
						bundle.slots[1] = c_vol;
						bundle.slots[2] = c_pitch;
						bundle.slots[3] = c_keyon;
						bundle.count = 3'd4;
					end else begin
						bundle.slots[0] = c_vol;
						bundle.slots[1] = c_pitch;
						bundle.slots[2] = c_keyon;
						bundle.count = 3'd3;
					end
				end
				fmmap_pkg::OP_NOTE_OFF: begin
					bundle.slots[0] = c_keyoff;
					bundle.count = 3'd1;
				end
				fmmap_pkg::OP_VOLUME: begin
					bundle.slots[0] = c_vol;
					bundle.count = 3'd1;
				end
				fmmap_pkg::OP_BEND: begin
					bundle.slots[0] = c_bend;
					bundle.count = 3'd1;
				end
				fmmap_pkg::OP_PROGRAM: begin
					bundle.slots[0] = c_preset;
					bundle.slots[1] = c_stereo;
					bundle.count = 3'd2;
				end
				fmmap_pkg::OP_PAN: begin
					bundle.slots[0] = c_stereo;
					bundle.count = 3'd1;
				end
				default: bundle.count = 3'd0;
			endcase
		end
	end

	// an event with no commands leaves without waiting for the output
	assign bundle_valid = s2_valid_q & (bundle.count != '0);
	assign s2_go = s2_valid_q & ((bundle.count == '0) | free);
	assign s2_ready = ~s2_valid_q | s2_go;

	// a list is handed over only when the output side can take it
	a_go_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && bundle.count != '0) |-> free)
		else $error("command list left stage 2 while output busy");

endmodule

`default_nettype wire

FILE: hw/rtl/fmmap_emit.sv
// fmmap_emit: output register of the mapper. Holds the commands of one event
// and sends them one per cycle while fm_ready is high, marking the last one.
// Depends on fmmap_pkg.
`default_nettype none

module fmmap_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                bundle_valid,
	input  wire fmmap_pkg::bundle_t  bundle,
	output logic                     free,
	output logic                     fm_valid,
	input  wire logic                fm_ready,
	output fmmap_pkg::fm_item_t      fm
);

	fmmap_pkg::fm_item_t [fmmap_pkg::MAX_CMDS-1:0] slots_q;
	logic [fmmap_pkg::IDX_W-1:0] idx_q;
	logic [fmmap_pkg::CNT_W-1:0] cnt_q;
	logic pop;
	logic load;

	assign fm_valid = (cnt_q != '0);
	assign pop = fm_valid & fm_ready;
	assign free = (cnt_q == '0) | (pop & (cnt_q == 3'd1));
	assign load = bundle_valid & free;

	// count of commands still to send, and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.count;
			idx_q <= '0;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= bundle.slots;
		end
	end

	// current command, last flag from the count
	always_comb begin
		fm = slots_q[idx_q];
		fm.is_last = (cnt_q == 3'd1);
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(fmmap_pkg::MAX_CMDS))
		else $error("output count beyond list size");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q == 3'd1 && !load) |=> !fm_valid)
		else $error("output valid after last command taken");

endmodule

`default_nettype wire

FILE: hw/rtl/midi_to_fm_channel_mapper_unit.sv
// midi_to_fm_channel_mapper_unit: top level of the MIDI-to-FM channel mapper.
// Instantiates fmmap_state, fmmap_calc and fmmap_emit; depends on fmmap_pkg.
//
// Usage:
//   midi (midi_valid/midi_ready) takes one MIDI event item per handshake.
//   fm (fm_valid/fm_ready) gives the FM command items of each event in order,
//   zero to four per event, with is_last set on the final one.
//   Path: an accepted event is registered in stage 1 (state read), then in
//   stage 2 (arithmetic), and its first command is valid once the output
//   register loads.
//   Throughput: one event per cycle while fm_ready is high and each event
//   yields at most one command; the single output register sends one command
//   per cycle while fm_ready is high, so a note-on (three or four commands)
//   or a program change (two) holds it until all are taken. It reloads in the
//   cycle its last command is taken, so commands leave back to back.
//   Reset: channel state returns to pitch 0, volume 127, velocity 127, pan 0,
//   not percussive, through per-channel valid bits (no clearing pass). The
//   percussion key table is not cleared and must be loaded before use.
//   Stall: when fm_ready is low the output holds its command and the pipeline
//   fills; midi_ready falls once all stages are occupied.
`default_nettype none

module midi_to_fm_channel_mapper_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  midi_valid,
	output logic                       midi_ready,
	input  wire fmmap_pkg::midi_item_t midi,
	output logic                       fm_valid,
	input  wire logic                  fm_ready,
	output fmmap_pkg::fm_item_t        fm
);

	logic               s1_valid;
	fmmap_pkg::s1_t     s1;
	logic               s2_ready;
	logic               free;
	logic               bundle_valid;
	fmmap_pkg::bundle_t bundle;

	fmmap_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.midi_valid (midi_valid),
		.midi_ready (midi_ready),
		.midi       (midi),
		.s2_ready   (s2_ready),
		.s1_valid   (s1_valid),
		.s1         (s1)
	);

	fmmap_calc u_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.s1           (s1),
		.s2_ready     (s2_ready),
		.free         (free),
		.bundle_valid (bundle_valid),
		.bundle       (bundle)
	);

	fmmap_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle_valid (bundle_valid),
		.bundle       (bundle),
		.free         (free),
		.fm_valid     (fm_valid),
		.fm_ready     (fm_ready),
		.fm           (fm)
	);

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for midi_to_fm_channel_mapper_unit.
// Drives MIDI event items, predicts the FM command items of each event and
// checks them in order; depends on fmmap_pkg and the mapper RTL.

module tb_top;

	localparam int RANDOM_EVENTS = 78;
	localparam int CALM_TAIL = 30;
	localparam int CYCLE_LIMIT = 50000;
	localparam int HOLD_AT = 40;
	localparam int HOLD_CYCLES = 90;

	localparam logic [10:0] FNUM_STEPS [12] = '{
		11'd617, 11'd653, 11'd692, 11'd733, 11'd777, 11'd823,
		11'd872, 11'd924, 11'd979, 11'd1037, 11'd1099, 11'd1164
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic midi_valid = 1'b0;
	logic midi_ready;
	fmmap_pkg::midi_item_t midi = '0;
	logic fm_valid;
	logic fm_ready = 1'b0;
	fmmap_pkg::fm_item_t fm;

	midi_to_fm_channel_mapper_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.midi_valid(midi_valid),
		.midi_ready(midi_ready),
		.midi(midi),
		.fm_valid(fm_valid),
		.fm_ready(fm_ready),
		.fm(fm)
	);

	// predicted channel state
	logic [6:0] ch_pitch [fmmap_pkg::NUM_CHANNELS];
	logic [6:0] ch_volume [fmmap_pkg::NUM_CHANNELS];
	logic [6:0] ch_velocity [fmmap_pkg::NUM_CHANNELS];
	logic [6:0] ch_pan [fmmap_pkg::NUM_CHANNELS];
	logic ch_perc [fmmap_pkg::NUM_CHANNELS];
	logic [6:0] perc_keys [128];

	// stimulus-side view, used only to keep percussion reads on loaded entries
	logic gen_perc [8];
	logic key_written [128];
	int loaded_notes [$];

	fmmap_pkg::midi_item_t events_todo [$];
	fmmap_pkg::fm_item_t cmds_due [$];

	int total_items = 0;
	int midi_accepted = 0;
	int cmds_checked = 0;
	int perc_loads = 0;
	int errors = 0;
	int op_seen [8];
	int cycle_cnt = 0;
	int send_gap = 0;
	int rdy_gap = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	fmmap_pkg::fm_item_t want;

	// no idling in the tail, and a quiet stretch every third group of 16 items
	wire calm = (midi_accepted + CALM_TAIL >= total_items);
	wire quiet_stretch = ((midi_accepted / 16) % 3) == 2;
	wire idle_ok = !calm && !quiet_stretch;

	initial forever #2 clk = ~clk;

	// ---------------- prediction ----------------

	function automatic int octave_of(input logic [6:0] key);
		if (key < fmmap_pkg::LOW_NOTE)
			return 0;
		return (int'(key) - int'(fmmap_pkg::LOW_NOTE)) / int'(fmmap_pkg::STEPS);
	endfunction

	// the offset from the lowest note wraps on 8 bits
	function automatic logic [10:0] base_fnum(input logic [6:0] key);
		logic [7:0] d;
		d = {1'b0, key} - {1'b0, fmmap_pkg::LOW_NOTE};
		return FNUM_STEPS[int'(d) % 12];
	endfunction

	function automatic logic [6:0] level_of(input int ch);
		int v;
		v = (int'(ch_volume[ch]) * int'(ch_velocity[ch])) / int'(fmmap_pkg::LEVEL_MAX);
		return v[6:0];
	endfunction

	function automatic fmmap_pkg::stereo_t stereo_of(input logic [6:0] p);
		if (p > fmmap_pkg::PAN_RIGHT_MIN)
			return fmmap_pkg::ST_RIGHT;
		if (p > fmmap_pkg::PAN_CENTER_MIN)
			return fmmap_pkg::ST_CENTER;
		return fmmap_pkg::ST_LEFT;
	endfunction

	function automatic fmmap_pkg::fm_item_t blank_cmd(input fmmap_pkg::cmd_t k,
			input logic [2:0] ch);
		fmmap_pkg::fm_item_t c;
		c = '0;
		c.cmd = k;
		c.out_chan = ch;
		return c;
	endfunction

	// expected FM commands of one accepted MIDI event
	task automatic map_event(input fmmap_pkg::midi_item_t ev);
		fmmap_pkg::fm_item_t outs [$];
		fmmap_pkg::fm_item_t c;
		logic [6:0] key;
		int ch;
		int rel;
		int fn;
		ch = int'(ev.chan);
		op_seen[ev.op]++;
		if (ev.op == fmmap_pkg::OP_LOAD_PERC_KEY) begin
			perc_keys[ev.note] = ev.perc_key;
			return;
		end
		if (ch >= fmmap_pkg::NUM_CHANNELS)
			return;
		case (ev.op)
			fmmap_pkg::OP_NOTE_ON: begin
				if (ev.note >= fmmap_pkg::LOW_NOTE && ev.note <= fmmap_pkg::HIGH_NOTE) begin
					key = ev.note;
					if (ch_perc[ch]) begin
						c = blank_cmd(fmmap_pkg::CMD_LOAD_PERC_PRESET, ev.chan);
						c.preset_index = ev.note;
						outs.push_back(c);
						key = perc_keys[ev.note];
					end
					ch_velocity[ch] = ev.velocity;
					c = blank_cmd(fmmap_pkg::CMD_VOLUME, ev.chan);
					c.level = level_of(ch);
					outs.push_back(c);
					ch_pitch[ch] = key;
					c = blank_cmd(fmmap_pkg::CMD_PITCH, ev.chan);
					c.octave = 4'(octave_of(key));
					c.fnum = base_fnum(key);
					outs.push_back(c);
					outs.push_back(blank_cmd(fmmap_pkg::CMD_KEY_ON, ev.chan));
				end
			end
			fmmap_pkg::OP_NOTE_OFF: outs.push_back(blank_cmd(fmmap_pkg::CMD_KEY_OFF, ev.chan));
			fmmap_pkg::OP_VOLUME: begin
				ch_volume[ch] = ev.volume;
				c = blank_cmd(fmmap_pkg::CMD_VOLUME, ev.chan);
				c.level = level_of(ch);
				outs.push_back(c);
			end
			fmmap_pkg::OP_BEND: begin
				// quotient truncates toward zero
				rel = int'(ev.bend) - int'(fmmap_pkg::BEND_CENTER);
				fn = int'(base_fnum(ch_pitch[ch])) + rel / int'(fmmap_pkg::BEND_DIV);
				c = blank_cmd(fmmap_pkg::CMD_PITCH, ev.chan);
				c.octave = 4'(octave_of(ch_pitch[ch]));
				c.fnum = fn[10:0];
				outs.push_back(c);
			end
			fmmap_pkg::OP_PROGRAM: begin
				c = blank_cmd(fmmap_pkg::CMD_LOAD_PRESET, ev.chan);
				c.preset_index = ev.program_req;
				outs.push_back(c);
				c = blank_cmd(fmmap_pkg::CMD_STEREO, ev.chan);
				c.stereo = stereo_of(ch_pan[ch]);
				outs.push_back(c);
			end
			fmmap_pkg::OP_PERCUSSIVE: ch_perc[ch] = ev.enabled;
			default: begin
				ch_pan[ch] = ev.pan;
				c = blank_cmd(fmmap_pkg::CMD_STEREO, ev.chan);
				c.stereo = stereo_of(ev.pan);
				outs.push_back(c);
			end
		endcase
		if (outs.size() > 0)
			outs[outs.size() - 1].is_last = 1'b1;
		foreach (outs[i])
			cmds_due.push_back(outs[i]);
	endtask

	// ---------------- checking ----------------

	task automatic field_check(input string name, input logic [10:0] exp_v,
			input logic [10:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	task automatic compare_cmd(input fmmap_pkg::fm_item_t exp_c,
			input fmmap_pkg::fm_item_t act_c);
		field_check("cmd", 11'(exp_c.cmd), 11'(act_c.cmd));
		field_check("out_chan", 11'(exp_c.out_chan), 11'(act_c.out_chan));
		field_check("level", 11'(exp_c.level), 11'(act_c.level));
		field_check("octave", 11'(exp_c.octave), 11'(act_c.octave));
		field_check("fnum", exp_c.fnum, act_c.fnum);
		field_check("stereo", 11'(exp_c.stereo), 11'(act_c.stereo));
		field_check("preset_index", 11'(exp_c.preset_index), 11'(act_c.preset_index));
		field_check("is_last", 11'(exp_c.is_last), 11'(act_c.is_last));
	endtask

	// ---------------- stimulus ----------------

	function automatic fmmap_pkg::midi_item_t noise_item();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return fmmap_pkg::midi_item_t'(bits[$bits(fmmap_pkg::midi_item_t)-1:0]);
	endfunction

	// keeps percussive note-ons on loaded table entries
	task automatic queue_event(input fmmap_pkg::midi_item_t ev);
		fmmap_pkg::midi_item_t e;
		e = ev;
		if (e.op == fmmap_pkg::OP_LOAD_PERC_KEY) begin
			if (!key_written[e.note] && e.note >= fmmap_pkg::LOW_NOTE
					&& e.note <= fmmap_pkg::HIGH_NOTE)
				loaded_notes.push_back(int'(e.note));
			key_written[e.note] = 1'b1;
		end else if (e.chan < fmmap_pkg::NUM_CHANNELS) begin
			if (e.op == fmmap_pkg::OP_PERCUSSIVE)
				gen_perc[e.chan] = e.enabled;
			if (e.op == fmmap_pkg::OP_NOTE_ON && gen_perc[e.chan]
					&& e.note >= fmmap_pkg::LOW_NOTE && e.note <= fmmap_pkg::HIGH_NOTE
					&& !key_written[e.note])
				e.note = 7'(loaded_notes[$urandom_range(0, loaded_notes.size() - 1)]);
		end
		events_todo.push_back(e);
	endtask

	// a and b carry the op's own fields; the rest stays random
	task automatic directed(input fmmap_pkg::op_t op, input int ch, input int a,
			input int b);
		fmmap_pkg::midi_item_t ev;
		ev = noise_item();
		ev.op = op;
		ev.chan = 3'(ch);
		case (op)
			fmmap_pkg::OP_NOTE_ON: begin
				ev.note = 7'(a);
				ev.velocity = 7'(b);
			end
			fmmap_pkg::OP_VOLUME: ev.volume = 7'(a);
			fmmap_pkg::OP_BEND: ev.bend = 14'(a);
			fmmap_pkg::OP_PROGRAM: ev.program_req = 7'(a);
			fmmap_pkg::OP_PERCUSSIVE: ev.enabled = a[0];
			fmmap_pkg::OP_PAN: ev.pan = 7'(a);
			fmmap_pkg::OP_LOAD_PERC_KEY: begin
				ev.note = 7'(a);
				ev.perc_key = 7'(b);
			end
			default: ;
		endcase
		queue_event(ev);
	endtask

	task automatic random_events();
		fmmap_pkg::midi_item_t ev;
		int useful;
		int r;
		useful = 0;
		while (useful < RANDOM_EVENTS) begin
			ev = noise_item();
			r = $urandom_range(0, 99);
			ev.chan = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, fmmap_pkg::NUM_CHANNELS - 1));
			if (r < 40) begin
				ev.op = fmmap_pkg::OP_NOTE_ON;
				if ($urandom_range(0, 7) != 0)
					ev.note = 7'($urandom_range(fmmap_pkg::LOW_NOTE, fmmap_pkg::HIGH_NOTE));
			end else if (r < 50)
				ev.op = fmmap_pkg::OP_NOTE_OFF;
			else if (r < 58)
				ev.op = fmmap_pkg::OP_VOLUME;
			else if (r < 68)
				ev.op = fmmap_pkg::OP_BEND;
			else if (r < 76)
				ev.op = fmmap_pkg::OP_PROGRAM;
			else if (r < 84)
				ev.op = fmmap_pkg::OP_PERCUSSIVE;
			else if (r < 92)
				ev.op = fmmap_pkg::OP_PAN;
			else
				ev.op = fmmap_pkg::OP_LOAD_PERC_KEY;
			if (ev.op == fmmap_pkg::OP_LOAD_PERC_KEY || (ev.chan < fmmap_pkg::NUM_CHANNELS
					&& !(ev.op == fmmap_pkg::OP_NOTE_ON && (ev.note < fmmap_pkg::LOW_NOTE
					|| ev.note > fmmap_pkg::HIGH_NOTE))))
				useful++;
			queue_event(ev);
		end
	endtask

	// ---------------- driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (midi_valid && midi_ready) begin
				map_event(midi);
				midi_accepted <= midi_accepted + 1;
			end
			// present the next item once the current one is gone
			if (!midi_valid || midi_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					midi_valid <= 1'b0;
				end else if (events_todo.size() == 0)
					midi_valid <= 1'b0;
				else if (idle_ok && $urandom_range(0, 4) == 0) begin
					send_gap <= $urandom_range(0, 6);
					midi_valid <= 1'b0;
				end else begin
					midi <= events_todo.pop_front();
					midi_valid <= 1'b1;
				end
			end
		end
	end

	// long receiver hold-off so the pipeline fills and backs up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && midi_accepted >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// ---------------- monitor ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fm_ready <= 1'b0;
			rdy_gap <= 0;
		end else begin
			if (fm_valid && fm_ready) begin
				if (cmds_due.size() == 0) begin
					errors++;
					$display("%0t: command with none expected, got %p", $time, fm);
				end else begin
					want = cmds_due.pop_front();
					if (want.cmd == fmmap_pkg::CMD_LOAD_PERC_PRESET)
						perc_loads++;
					compare_cmd(want, fm);
					cmds_checked++;
				end
			end
			if (hold_left != 0)
				fm_ready <= 1'b0;
			else if (rdy_gap != 0) begin
				rdy_gap <= rdy_gap - 1;
				fm_ready <= 1'b0;
			end else if (idle_ok && $urandom_range(0, 4) == 0) begin
				rdy_gap <= $urandom_range(0, 6);
				fm_ready <= 1'b0;
			end else
				fm_ready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d commands outstanding", $time, cmds_due.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		for (int i = 0; i < fmmap_pkg::NUM_CHANNELS; i++) begin
			ch_pitch[i] = 7'd0;
			ch_volume[i] = 7'd127;
			ch_velocity[i] = 7'd127;
			ch_pan[i] = 7'd0;
			ch_perc[i] = 1'b0;
		end
		foreach (perc_keys[i]) begin
			perc_keys[i] = 7'd0;
			key_written[i] = 1'b0;
		end
		foreach (gen_perc[i])
			gen_perc[i] = 1'b0;
		foreach (op_seen[i])
			op_seen[i] = 0;

		// table loads first, including the lowest and highest remapped keys
		directed(fmmap_pkg::OP_LOAD_PERC_KEY, 0, 11, 0);
		directed(fmmap_pkg::OP_LOAD_PERC_KEY, 3, 106, 127);
		directed(fmmap_pkg::OP_LOAD_PERC_KEY, 5, 60, 35);
		directed(fmmap_pkg::OP_LOAD_PERC_KEY, 7, 0, 127);
		directed(fmmap_pkg::OP_LOAD_PERC_KEY, 6, 127, 5);
		// note window edges, in and out
		directed(fmmap_pkg::OP_NOTE_ON, 0, 11, 127);
		directed(fmmap_pkg::OP_NOTE_ON, 5, 106, 0);
		directed(fmmap_pkg::OP_NOTE_ON, 1, 10, 64);
		directed(fmmap_pkg::OP_NOTE_ON, 1, 107, 64);
		directed(fmmap_pkg::OP_NOTE_ON, 2, 0, 127);
		directed(fmmap_pkg::OP_NOTE_OFF, 1, 0, 0);
		directed(fmmap_pkg::OP_VOLUME, 0, 0, 0);
		directed(fmmap_pkg::OP_VOLUME, 0, 127, 0);
		// bend extremes, and bend on a channel still at reset pitch
		directed(fmmap_pkg::OP_BEND, 0, 0, 0);
		directed(fmmap_pkg::OP_BEND, 0, 16383, 0);
		directed(fmmap_pkg::OP_BEND, 2, 8192, 0);
		// pan thresholds
		directed(fmmap_pkg::OP_PROGRAM, 3, 0, 0);
		directed(fmmap_pkg::OP_PAN, 3, 31, 0);
		directed(fmmap_pkg::OP_PAN, 3, 32, 0);
		directed(fmmap_pkg::OP_PAN, 3, 96, 0);
		directed(fmmap_pkg::OP_PAN, 3, 97, 0);
		directed(fmmap_pkg::OP_PROGRAM, 3, 127, 0);
		// percussive channel with remapped keys below and above the window
		directed(fmmap_pkg::OP_PERCUSSIVE, 4, 1, 0);
		directed(fmmap_pkg::OP_NOTE_ON, 4, 11, 90);
		directed(fmmap_pkg::OP_NOTE_ON, 4, 106, 127);
		directed(fmmap_pkg::OP_NOTE_ON, 4, 60, 1);
		directed(fmmap_pkg::OP_PERCUSSIVE, 4, 0, 0);
		// channels past the last one are ignored
		directed(fmmap_pkg::OP_NOTE_ON, 7, 60, 100);
		directed(fmmap_pkg::OP_VOLUME, 6, 5, 0);
		random_events();
		total_items = events_todo.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (events_todo.size() != 0 || midi_valid || cmds_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d MIDI events through all eight event types; %0d FM commands checked,",
			midi_accepted, cmds_checked);
		$display("%0d percussion preset loads, note-ons %0d, bends %0d, one long output stall.",
			perc_loads, op_seen[fmmap_pkg::OP_NOTE_ON], op_seen[fmmap_pkg::OP_BEND]);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
